// ===== hw/rtl/sliding_window_min_previous_unit_assert.svh =====
// Assertion macros for the sliding window minimum block.
`ifndef SLIDING_WINDOW_MIN_PREVIOUS_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_MIN_PREVIOUS_UNIT_ASSERT_SVH
`ifndef SYNTH
`define SWMP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SWMP_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWMP_ASSERT(lbl, clk, rst_n, prop, msg)
`define SWMP_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/swmp_pkg.sv =====
package swmp_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int CFG_BITS        = 7;
    localparam int AGE_MOD         = 128;

    typedef struct packed {
        logic                adv;
        logic                clr;
        logic [CFG_BITS-1:0] win;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/swmp_cell.sv =====
module swmp_cell #(
    parameter int                           SAMPLE_BITS = swmp_pkg::SAMPLE_BITS_DEF,
    parameter logic [swmp_pkg::CFG_BITS-1:0] AGE        = swmp_pkg::CFG_BITS'(1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  swmp_pkg::cell_ctrl_t          ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic signed [SAMPLE_BITS-1:0] up_value,
    input  logic                          up_valid,
    output logic                          live,
    output logic signed [SAMPLE_BITS-1:0] value,
    output logic signed [SAMPLE_BITS-1:0] dn_value,
    output logic                          dn_valid
);

    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic                          valid_reg;
    logic                          in_window;

    assign in_window = (AGE <= ctrl.win);
    assign live      = valid_reg && !ctrl.clr && in_window;
    assign value     = value_reg;
    assign dn_value  = value_reg;
    // survives eviction only if strictly below the new sample
    assign dn_valid  = live && (value_reg < sample);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.adv) begin
            valid_reg <= up_valid && in_window;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            value_reg <= up_value;
        end
    end

endmodule

// ===== hw/rtl/swmp_min_tree.sv =====
module swmp_min_tree #(
    parameter int WINDOW_MAX  = swmp_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swmp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          live      [WINDOW_MAX],
    input  logic signed [SAMPLE_BITS-1:0] cell_value [WINDOW_MAX],
    output logic                          found,
    output logic signed [SAMPLE_BITS-1:0] min_value
);

    // candidates are increasing toward younger cells: the oldest live one is the minimum
    localparam int LEVELS = $clog2(WINDOW_MAX);
    localparam int N      = 1 << LEVELS;

    logic                          lv_vld [LEVELS+1][N];
    logic signed [SAMPLE_BITS-1:0] lv_val [LEVELS+1][N];

    for (genvar i = 0; i < N; i++) begin : g_leaf
        if (i < WINDOW_MAX) begin : g_used
            assign lv_vld[0][i] = live[i];
            assign lv_val[0][i] = cell_value[i];
        end else begin : g_pad
            assign lv_vld[0][i] = 1'b0;
            assign lv_val[0][i] = '0;
        end
    end

    for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
        for (genvar i = 0; i < N; i++) begin : g_node
            if (i < (N >> (l + 1))) begin : g_pick
                assign lv_vld[l+1][i] = lv_vld[l][2*i+1] || lv_vld[l][2*i];
                assign lv_val[l+1][i] = lv_vld[l][2*i+1] ? lv_val[l][2*i+1]
                                                         : lv_val[l][2*i];
            end else begin : g_idle
                assign lv_vld[l+1][i] = 1'b0;
                assign lv_val[l+1][i] = '0;
            end
        end
    end

    assign found     = lv_vld[LEVELS][0];
    assign min_value = lv_val[LEVELS][0];

endmodule

// ===== hw/rtl/sliding_window_min_previous_unit.sv =====
// Sliding window minimum of preceding samples.
// Input channel s_*: one signed sample per transfer, with s_clear_history to
// start a new sequence. Output channel m_*: one result per input, the minimum
// of the previous window_len samples, or 0 with m_history_empty set when no
// earlier sample exists in the current sequence.
// cfg_we/cfg_wdata write window_len (0 acts as 1, values above WINDOW_MAX
// saturate); write only while no transfer is in flight.
// Result: registered, valid in the cycle after its input transfer.
// Throughput: one item per cycle unless the output stalls; each cell of the
// candidate chain compares, evicts and shifts in the same cycle, and the
// minimum comes from a log2(WINDOW_MAX)-level select over the live cells.
// Reset: all candidates are invalid at once, window_len is 1, no clearing pass.
// Stall: when a result is pending and m_ready is low, the result register holds
// and s_ready drops, so the chain advances only when the result slot is free or being drained.
module sliding_window_min_previous_unit #(
    parameter int WINDOW_MAX  = swmp_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swmp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [swmp_pkg::CFG_BITS-1:0]     cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [SAMPLE_BITS-1:0]     s_sample,
    input  logic                              s_clear_history,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [SAMPLE_BITS-1:0]     m_min_prev,
    output logic                              m_history_empty
);

    `include "sliding_window_min_previous_unit_assert.svh"

    logic [swmp_pkg::CFG_BITS-1:0] win_reg, win_next;
    logic                          m_valid_reg, m_valid_next;
    logic signed [SAMPLE_BITS-1:0] m_min_prev_reg;
    logic                          m_history_empty_reg;
    logic                          s_fire;
    swmp_pkg::cell_ctrl_t          ctrl;

    logic                          live     [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] cell_val [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] dn_value [WINDOW_MAX];
    logic                          dn_valid [WINDOW_MAX];
    logic                          found;
    logic signed [SAMPLE_BITS-1:0] min_value;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    assign ctrl.adv = s_fire;
    assign ctrl.clr = s_clear_history;
    assign ctrl.win = win_reg;

    always_comb begin
        if (cfg_wdata == '0) begin
            win_next = swmp_pkg::CFG_BITS'(1);
        end else if (32'(cfg_wdata) > 32'(WINDOW_MAX)) begin
            win_next = swmp_pkg::CFG_BITS'(WINDOW_MAX);
        end else begin
            win_next = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= swmp_pkg::CFG_BITS'(1);
        end else if (cfg_we) begin
            win_reg <= win_next;
        end
    end

    for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
        logic signed [SAMPLE_BITS-1:0] up_value;
        logic                          up_valid;
        if (k == 0) begin : g_head
            assign up_value = s_sample;
            assign up_valid = 1'b1;
        end else begin : g_link
            assign up_value = dn_value[k-1];
            assign up_valid = dn_valid[k-1];
        end
        swmp_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .AGE         (swmp_pkg::CFG_BITS'((k + 1) % swmp_pkg::AGE_MOD))
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .sample   (s_sample),
            .up_value (up_value),
            .up_valid (up_valid),
            .live     (live[k]),
            .value    (cell_val[k]),
            .dn_value (dn_value[k]),
            .dn_valid (dn_valid[k])
        );
    end

    swmp_min_tree #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_min_tree (
        .live       (live),
        .cell_value (cell_val),
        .found      (found),
        .min_value  (min_value)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_min_prev_reg      <= found ? min_value : '0;
            m_history_empty_reg <= !found;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_min_prev      = m_min_prev_reg;
    assign m_history_empty = m_history_empty_reg;

    `SWMP_ASSERT(a_clear_empty, aclk, aresetn, s_fire && s_clear_history |=> m_valid && m_history_empty, "clear did not give an empty result")
    `SWMP_ASSERT(a_prev_seen, aclk, aresetn, s_fire ##1 (s_fire && !s_clear_history) |=> !m_history_empty, "previous sample missing from history")
    `SWMP_ASSERT(a_min_bound, aclk, aresetn, s_fire ##1 (s_fire && !s_clear_history) |=> m_min_prev <= $past(s_sample, 2), "minimum above previous sample")
    `SWMP_ASSERT_RST(a_reset_idle, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

    localparam int WMAX       = swmp_pkg::WINDOW_MAX_DEF;
    localparam int SB         = swmp_pkg::SAMPLE_BITS_DEF;
    localparam int CYCLE_CAP  = 400000;
    localparam int PRINT_CAP  = 40;

    typedef struct {
        logic signed [SB-1:0] sample;
        logic                 clr;
    } sample_item_t;

    typedef struct {
        logic signed [SB-1:0] min_prev;
        logic                 empty;
    } min_result_t;

    logic                          aclk            = 1'b0;
    logic                          aresetn         = 1'b0;
    logic                          cfg_we          = 1'b0;
    logic [swmp_pkg::CFG_BITS-1:0] cfg_wdata       = '0;
    logic                          s_valid         = 1'b0;
    logic                          s_ready;
    logic signed [SB-1:0]          s_sample        = '0;
    logic                          s_clear_history = 1'b0;
    logic                          m_valid;
    logic                          m_ready         = 1'b0;
    logic signed [SB-1:0]          m_min_prev;
    logic                          m_history_empty;

    sliding_window_min_previous_unit #(
        .WINDOW_MAX  (WMAX),
        .SAMPLE_BITS (SB)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_clear_history (s_clear_history),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_min_prev      (m_min_prev),
        .m_history_empty (m_history_empty)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // window-minimum predictor state
    logic signed [SB-1:0]          hist_val  [WMAX];
    logic [swmp_pkg::CFG_BITS-1:0] hist_age  [WMAX];
    logic                          hist_live [WMAX];
    logic                          hist_seen;
    logic [swmp_pkg::CFG_BITS-1:0] win_len_model;

    sample_item_t sample_q   [$];
    min_result_t  min_prev_q [$];
    sample_item_t cur_item;
    min_result_t  got_exp;

    int  err_cnt   = 0;
    int  cycles    = 0;
    int  drv_gap   = 0;
    int  rcv_stall = 0;
    bit  idle_on   = 1'b1;

    task automatic report_mismatch(input string msg);
        if (err_cnt < PRINT_CAP)
            $display("MISMATCH @%0d: %s", cycles, msg);
        err_cnt++;
    endtask

    function automatic int eff_window();
        int w;
        w = int'(win_len_model);
        if (w == 0)
            w = 1;
        if (w > WMAX)
            w = WMAX;
        return w;
    endfunction

    function automatic void drop_aged(input int w);
        for (int k = 0; k < WMAX; k++)
            if (hist_live[k] && int'(hist_age[k]) > w)
                hist_live[k] = 1'b0;
    endfunction

    function automatic min_result_t calc_min_prev(input sample_item_t it);
        min_result_t          r;
        int                   w;
        logic                 found;
        logic signed [SB-1:0] best;
        w     = eff_window();
        found = 1'b0;
        best  = '0;
        if (it.clr) begin
            for (int k = 0; k < WMAX; k++)
                hist_live[k] = 1'b0;
            hist_seen = 1'b0;
        end
        drop_aged(w);
        for (int k = 0; k < WMAX; k++)
            if (hist_live[k] && (!found || best >= hist_val[k])) begin
                best  = hist_val[k];
                found = 1'b1;
            end
        r.empty    = !(hist_seen && found);
        r.min_prev = r.empty ? '0 : best;
        for (int k = 0; k < WMAX; k++)
            if (hist_live[k] && hist_val[k] >= it.sample)
                hist_live[k] = 1'b0;
        for (int k = WMAX - 1; k > 0; k--) begin
            hist_val[k]  = hist_val[k-1];
            hist_age[k]  = hist_age[k-1] + 1'b1;
            hist_live[k] = hist_live[k-1];
        end
        hist_val[0]  = it.sample;
        hist_age[0]  = swmp_pkg::CFG_BITS'(1);
        hist_live[0] = 1'b1;
        drop_aged(w);
        hist_seen = 1'b1;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                min_prev_q.insert(min_prev_q.size(), calc_min_prev(cur_item));
            if (!(s_valid && !s_ready)) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    s_valid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    cur_item = sample_q[0];
                    sample_q.delete(0);
                    s_valid         <= 1'b1;
                    s_sample        <= cur_item.sample;
                    s_clear_history <= cur_item.clr;
                    drv_gap = pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (min_prev_q.size() == 0) begin
                    report_mismatch("result transfer with no expectation pending");
                end else begin
                    got_exp = min_prev_q[0];
                    min_prev_q.delete(0);
                    if (m_min_prev !== got_exp.min_prev)
                        report_mismatch($sformatf("min_prev got %0d exp %0d",
                                                  m_min_prev, got_exp.min_prev));
                    if (m_history_empty !== got_exp.empty)
                        report_mismatch($sformatf("history_empty got %0b exp %0b",
                                                  m_history_empty, got_exp.empty));
                end
            end
            if (rcv_stall > 0) begin
                rcv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                rcv_stall = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic add_item(input logic signed [SB-1:0] smp, input logic clr);
        sample_item_t it;
        it.sample = smp;
        it.clr    = clr;
        sample_q.insert(sample_q.size(), it);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (sample_q.size() != 0 || s_valid || min_prev_q.size() != 0);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_window(input int v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= swmp_pkg::CFG_BITS'(v);
        @(posedge aclk);
        cfg_we <= 1'b0;
        win_len_model = swmp_pkg::CFG_BITS'(v);
    endtask

    task automatic gen_random(input int n);
        int                   mode;
        int                   run;
        logic signed [SB-1:0] v;
        logic signed [SB-1:0] step;
        while (n > 0) begin
            mode = $urandom_range(0, 4);
            run  = (mode >= 2 && mode <= 3) ? $urandom_range(1, 80) : $urandom_range(1, 20);
            v    = $urandom();
            step = $urandom_range(0, 3);
            if (run > n)
                run = n;
            repeat (run) begin
                case (mode)
                    0: v = $urandom();
                    1: v = int'($urandom_range(0, 16)) - 8;
                    2: v = v + step;
                    3: v = v - step;
                    default: begin
                        case ($urandom_range(0, 3))
                            0: v = {1'b1, {(SB-1){1'b0}}};
                            1: v = {1'b0, {(SB-1){1'b1}}};
                            2: v = '0;
                            default: v = '1;
                        endcase
                    end
                endcase
                add_item(v, $urandom_range(0, 39) == 0);
                n--;
            end
        end
    endtask

    initial begin
        int wins [12];
        win_len_model = 1;
        hist_seen     = 1'b0;
        for (int k = 0; k < WMAX; k++) begin
            hist_val[k]  = '0;
            hist_age[k]  = '0;
            hist_live[k] = 1'b0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // default window of one, extremes, equal values, clear
        add_item(100, 1'b0);
        add_item(32'sh7FFF_FFFF, 1'b0);
        add_item(32'sh8000_0000, 1'b0);
        add_item(32'sh8000_0000, 1'b0);
        add_item(-1, 1'b0);
        add_item(0, 1'b0);
        add_item(1, 1'b1);
        add_item(1, 1'b0);
        wait_drained();

        write_window('0);
        add_item(5, 1'b0);
        add_item(-5, 1'b0);
        add_item(2, 1'b0);
        wait_drained();

        write_window('1);
        for (int i = 0; i < 10; i++)
            add_item(i, 1'b0);
        add_item(-3, 1'b0);
        add_item(32'sh7FFF_FFFF, 1'b0);
        wait_drained();

        // shrink then grow: expired candidates stay gone
        write_window(3);
        add_item(50, 1'b0);
        add_item(60, 1'b0);
        wait_drained();
        write_window(64);
        add_item(70, 1'b0);
        add_item(0, 1'b1);
        wait_drained();

        wins = '{64, 1, 127, 2, 0, 32, 100, 3, 63, 65, 0, 0};
        wins[10] = $urandom_range(0, 127);
        wins[11] = $urandom_range(1, 64);
        for (int p = 0; p < 12; p++) begin
            idle_on = (p % 4) != 1;
            write_window(wins[p]);
            gen_random(62);
            wait_drained();
        end

        repeat (5) @(posedge aclk);
        if (min_prev_q.size() != 0)
            report_mismatch("expectations left at end of run");
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
